### sv/clc_pkg.sv
package clc_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int TABLE_LEN     = 256;
    localparam int KEY_W         = 25;
    localparam int ACC_W         = 26;

    localparam logic [8:0]         IDENT_SLOT = 9'd256;
    localparam logic signed [15:0] GAIN_ONE   = 16'sd256;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LRU,
        ST_FILL,
        ST_READ
    } state_t;

endpackage

### sv/color_lut_cache_lru_unit.sv
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       func, multiplier, offset, slot, byte_index
// result    out        done high for one cycle    table_slot, hit, evicted, data
//
// An identity request, a read of the identity table or of a slot outside the cache
// answers straight from idle; a cached read goes through the READ state. A request scans
// the tags through one compare, one slot a cycle; a miss with the cache full also scans
// all last-used ages, and every miss fills 256 bytes through one adder, one byte a cycle.
// Reset clears the fill count and the use counter; slots are always filled in order, so
// the fill count stands in for per-slot valid bits and no clearing pass is needed.
// The receiver cannot stall: each result is shown on done for exactly one cycle.
module color_lut_cache_lru_unit #(
    parameter int SLOTS = clc_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [15:0] multiplier,
    input  logic signed [17:0] offset,
    input  logic        [8:0]  slot,
    input  logic        [7:0]  byte_index,
    output logic               done,
    output logic        [8:0]  table_slot,
    output logic               hit,
    output logic               evicted,
    output logic        [7:0]  data
);

    localparam int SW = $clog2(SLOTS);
    localparam int AW = SW + $clog2(clc_pkg::TABLE_LEN);
    localparam int KW = clc_pkg::KEY_W;
    localparam int CW = clc_pkg::ACC_W;
    localparam logic [SW:0] LAST_SLOT = (SW + 1)'(SLOTS - 1);
    localparam logic [SW:0] SLOT_COUNT = (SW + 1)'(SLOTS);

    // Storage: tags, ages and table bytes, each with one write and one registered read.
    logic [KW-1:0] key_mem [SLOTS];
    logic [31:0]   age_mem [SLOTS];
    logic [7:0]    tbl_mem [SLOTS * clc_pkg::TABLE_LEN];

    // Control state.
    clc_pkg::state_t state_reg, state_next;
    logic [SW:0] fill_cnt_reg, fill_cnt_next;
    logic [31:0] use_cnt_reg, use_cnt_next;
    logic        pend_reg, pend_next;
    logic        done_reg, done_next;

    // Datapath registers.
    logic [SW:0]   idx_reg, idx_next;
    logic [SW:0]   cmp_idx_reg, cmp_idx_next;
    logic [KW-1:0] key_reg, key_next;
    logic [KW-1:0] key_rd_reg;
    logic [31:0]   age_rd_reg;
    logic [31:0]   best_reg, best_next;
    logic [SW-1:0] best_idx_reg, best_idx_next;
    logic [SW-1:0] pick_reg, pick_next;
    logic [CW-1:0] gain_reg, gain_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [7:0]    byte_cnt_reg, byte_cnt_next;
    logic          evict_reg, evict_next;
    logic [7:0]    tbl_rd_reg;
    logic [8:0]    tslot_reg, tslot_next;
    logic          hit_reg, hit_next;
    logic          ev_reg, ev_next;
    logic [7:0]    data_reg, data_next;

    // Memory write controls.
    logic          key_we, age_we, tbl_we, tbl_re;
    logic [SW-1:0] wr_slot;
    logic [AW-1:0] tbl_raddr;
    logic [7:0]    fill_byte;

    // Request decode: quantized key, truncated toward zero.
    logic              accept;
    logic              is_ident;
    logic              slot_cached;
    logic signed [15:0] gain_half;
    logic signed [18:0] bias_ext, bias_q;
    logic [KW-1:0]     req_key;
    logic              tag_match, tag_past_end, age_older;

    assign accept   = start && !busy;
    assign is_ident = (multiplier == clc_pkg::GAIN_ONE) && (offset == 18'sd0);
    assign gain_half = (multiplier + {15'd0, multiplier[15]}) >>> 1;
    assign bias_ext  = {offset[17], offset};
    assign bias_q    = (bias_ext + (offset[17] ? 19'sd511 : 19'sd0)) >>> 9;
    assign req_key   = {gain_half[14:0], bias_q[9:0]};
    assign slot_cached = (slot != clc_pkg::IDENT_SLOT) && (32'(slot) < SLOTS);
    assign tbl_raddr   = {SW'(slot), byte_index};

    // The tag compare sees the entry read in the previous cycle.
    assign tag_past_end = cmp_idx_reg >= fill_cnt_reg;
    assign tag_match    = !tag_past_end && (key_rd_reg == key_reg);
    assign age_older    = (cmp_idx_reg == '0) || (age_rd_reg < best_reg);

    // Clamp of the running sum i*gain + bias to one byte.
    assign fill_byte = acc_reg[CW-1] ? 8'd0 :
                       (|acc_reg[CW-2:16]) ? 8'd255 : acc_reg[15:8];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            clc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == clc_pkg::FUNC_READ)
                    begin
                        if (slot_cached)
                            state_next = clc_pkg::ST_READ;
                    end
                    else if (!is_ident)
                    begin
                        state_next = clc_pkg::ST_SEARCH;
                    end
                end
            end
            clc_pkg::ST_SEARCH:
            begin
                if (pend_reg && tag_match)
                    state_next = clc_pkg::ST_IDLE;
                else if (pend_reg && tag_past_end)
                    state_next = (fill_cnt_reg < SLOT_COUNT) ? clc_pkg::ST_FILL
                                                             : clc_pkg::ST_LRU;
            end
            clc_pkg::ST_LRU:
            begin
                if (pend_reg && cmp_idx_reg == LAST_SLOT)
                    state_next = clc_pkg::ST_FILL;
            end
            clc_pkg::ST_FILL:
            begin
                if (byte_cnt_reg == 8'd255)
                    state_next = clc_pkg::ST_IDLE;
            end
            clc_pkg::ST_READ:
            begin
                state_next = clc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = clc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        use_cnt_next  = use_cnt_reg;
        pend_next     = 1'b0;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        key_next      = key_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        pick_next     = pick_reg;
        gain_next     = gain_reg;
        acc_next      = acc_reg;
        byte_cnt_next = byte_cnt_reg;
        evict_next    = evict_reg;
        tslot_next    = tslot_reg;
        hit_next      = hit_reg;
        ev_next       = ev_reg;
        data_next     = data_reg;
        key_we        = 1'b0;
        age_we        = 1'b0;
        tbl_we        = 1'b0;
        tbl_re        = 1'b0;
        wr_slot       = pick_reg;
        case (state_reg)
            clc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    tslot_next = 9'd0;
                    hit_next   = 1'b0;
                    ev_next    = 1'b0;
                    data_next  = 8'd0;
                    idx_next   = '0;
                    gain_next  = CW'(multiplier);
                    acc_next   = CW'(offset);
                    key_next   = req_key;
                    evict_next = 1'b0;
                    if (func == clc_pkg::FUNC_READ)
                    begin
                        tbl_re = slot_cached;
                        if (slot == clc_pkg::IDENT_SLOT)
                            data_next = byte_index;
                        done_next = !slot_cached;
                    end
                    else if (is_ident)
                    begin
                        tslot_next = clc_pkg::IDENT_SLOT;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        use_cnt_next = use_cnt_reg + 32'd1;
                    end
                end
            end
            clc_pkg::ST_SEARCH:
            begin
                idx_next     = idx_reg + 1'b1;
                cmp_idx_next = idx_reg;
                pend_next    = 1'b1;
                if (pend_reg && tag_match)
                begin
                    // Hit: refresh the age and report the slot.
                    wr_slot    = cmp_idx_reg[SW-1:0];
                    age_we     = 1'b1;
                    tslot_next = 9'(cmp_idx_reg);
                    hit_next   = 1'b1;
                    done_next  = 1'b1;
                end
                else if (pend_reg && tag_past_end)
                begin
                    idx_next = '0;
                    pend_next = 1'b0;
                    byte_cnt_next = 8'd0;
                    if (fill_cnt_reg < SLOT_COUNT)
                    begin
                        // A free slot remains: the next one in order takes the table.
                        wr_slot       = fill_cnt_reg[SW-1:0];
                        pick_next     = fill_cnt_reg[SW-1:0];
                        key_we        = 1'b1;
                        age_we        = 1'b1;
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                    end
                end
            end
            clc_pkg::ST_LRU:
            begin
                idx_next     = idx_reg + 1'b1;
                cmp_idx_next = idx_reg;
                pend_next    = 1'b1;
                if (pend_reg)
                begin
                    if (age_older)
                    begin
                        best_next     = age_rd_reg;
                        best_idx_next = cmp_idx_reg[SW-1:0];
                    end
                    if (cmp_idx_reg == LAST_SLOT)
                    begin
                        pend_next  = 1'b0;
                        pick_next  = age_older ? cmp_idx_reg[SW-1:0] : best_idx_reg;
                        wr_slot    = pick_next;
                        key_we     = 1'b1;
                        age_we     = 1'b1;
                        evict_next = 1'b1;
                    end
                end
            end
            clc_pkg::ST_FILL:
            begin
                tbl_we        = 1'b1;
                acc_next      = acc_reg + gain_reg;
                byte_cnt_next = byte_cnt_reg + 8'd1;
                if (byte_cnt_reg == 8'd255)
                begin
                    tslot_next = 9'(pick_reg);
                    ev_next    = evict_reg;
                    done_next  = 1'b1;
                end
            end
            clc_pkg::ST_READ:
            begin
                data_next = tbl_rd_reg;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= clc_pkg::ST_IDLE;
            fill_cnt_reg <= '0;
            use_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_cnt_reg <= fill_cnt_next;
            use_cnt_reg  <= use_cnt_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        key_reg      <= key_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        pick_reg     <= pick_next;
        gain_reg     <= gain_next;
        acc_reg      <= acc_next;
        byte_cnt_reg <= byte_cnt_next;
        evict_reg    <= evict_next;
        tslot_reg    <= tslot_next;
        hit_reg      <= hit_next;
        ev_reg       <= ev_next;
        data_reg     <= data_next;
    end

    // Tag and age memories: registered reads follow the scan index.
    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[idx_reg[SW-1:0]];
        age_rd_reg <= age_mem[idx_reg[SW-1:0]];
        if (key_we)
            key_mem[wr_slot] <= key_reg;
        if (age_we)
            age_mem[wr_slot] <= use_cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_re)
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        if (tbl_we)
            tbl_mem[{pick_reg, byte_cnt_reg}] <= fill_byte;
    end

    assign busy       = (state_reg != clc_pkg::ST_IDLE);
    assign done       = done_reg;
    assign table_slot = tslot_reg;
    assign hit        = hit_reg;
    assign evicted    = ev_reg;
    assign data       = data_reg;

`ifndef SYNTHESIS
    // A hit never evicts.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !(hit && evicted))
        else $error("hit and evicted together");
    // Valid slots never exceed the cache size.
    assert property (@(posedge clk) disable iff (!rst_n) fill_cnt_reg <= SLOT_COUNT)
        else $error("fill count beyond cache size");
    // Every accepted transaction either finishes at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (busy || done))
        else $error("accepted transaction lost");
    // A hit names a slot that has been filled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> ((SW + 1)'(table_slot) < fill_cnt_reg))
        else $error("hit on an unfilled slot");
`endif

endmodule
